>>> rtl/core/fspa_pkg.sv
// fspa_pkg: shared constants, codes and types of the fixed slot pool allocator.
// Used by fspa_divider, fspa_store and fixed_slot_pool_allocator_core.
package fspa_pkg;

	// address and slot size widths
	localparam int unsigned ADDR_BITS = 32;
	localparam int unsigned SLOT_W    = 17;

	// default sizing of the pool
	localparam int unsigned DEF_POOL_BYTES = 1024;
	localparam int unsigned DEF_MAX_SLOTS  = 256;

	// alignment register
	localparam int unsigned ALIGN_W = 4;
	localparam logic [ALIGN_W-1:0] ALIGN_MIN   = 4'd2;
	localparam logic [ALIGN_W-1:0] ALIGN_MAX   = 4'd10;
	localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd4;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_SHIFT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'b1;

	// stream words
	localparam int unsigned REQ_W      = 16;
	localparam int unsigned NUM_W      = 8;
	localparam int unsigned COUNT_W    = 9;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned IN_USER_W  = 1;
	localparam int unsigned OUT_DATA_W = 64;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_NOSPACE = 3'd2,
		ST_NOINIT  = 3'd3,
		ST_FOREIGN = 3'd4,
		ST_DOUBLE  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SETUP_START,
		S_SETUP_WAIT,
		S_ALLOC_CHK,
		S_ALLOC_IDX,
		S_ALLOC_MUL,
		S_ALLOC_ADD,
		S_FREE_SPAN,
		S_FREE_CMP,
		S_FREE_WAIT,
		S_FREE_RD,
		S_FREE_CHK,
		S_DONE
	} state_t;

endpackage

>>> rtl/core/fixed_slot_pool_allocator_core.sv
// fixed_slot_pool_allocator_core: top level of the pool allocator.
// Instantiates fspa_divider and fspa_store; uses fspa_pkg.
//
// Usage: one request word enters on s_axis (tuser = opcode, 0 allocate / 1 free;
// tdata = request size and free address). One result word leaves on m_axis per
// request: status, slot address, slot number and pool occupancy. The first
// nonzero allocate fixes the slot size and runs the slot count division.
// That division is POOL_BYTES / slot size; a free runs one address / slot size
// division. Zero size and free before setup are answered from decode, pool full
// at the free count check, an address past the last slot without a division and
// an address off a slot start once its division is done. All divisions share one
// restoring divider at one bit per cycle, and one request is worked at a time:
// s_axis_tready is high only while idle, from the cycle after the result is
// loaded, so no new request is taken while one is being worked. The result
// register lets the next request be taken while a result word waits; if m_axis
// stalls, the core holds its next finished result until taken. Reset clears the
// pool to uninitialized (no slot size, no slots). Ring and in-use memories need no
// clearing pass: a count of initial indices handed out tells which entries hold
// data. Configuration must be written only while idle; not checked by the core.
module fixed_slot_pool_allocator_core #(
	parameter int unsigned POOL_BYTES = fspa_pkg::DEF_POOL_BYTES,
	parameter int unsigned MAX_SLOTS  = fspa_pkg::DEF_MAX_SLOTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// request_bytes [15:0], free_addr [47:16]
	input  logic [fspa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// opcode [0]
	input  logic [fspa_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status [2:0], slot_addr [34:3], slot_number [42:35], slots_in_use [51:43],
	// slot_total [60:52], pool_full [61], zero [63:62]
	output logic [fspa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import fspa_pkg::*;

	localparam int unsigned IW = $clog2(MAX_SLOTS);
	localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
	localparam int unsigned PW = $clog2(POOL_BYTES + 1);
	localparam logic [IW-1:0] IDX_LAST = IW'(MAX_SLOTS - 1);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_SLOTS);
	localparam logic [ADDR_BITS-1:0] POOL_DIVIDEND = ADDR_BITS'(POOL_BYTES);

	state_t state_q, state_nxt;

	// configuration
	logic [ALIGN_W-1:0]   align_shift_q;
	logic [ADDR_BITS-1:0] pool_base_q;

	// pool state
	logic [SLOT_W-1:0] slot_bytes_q;
	logic [CW-1:0]     slot_count_q;
	logic [CW-1:0]     free_count_q;
	logic [CW-1:0]     init_taken_q;
	logic [IW-1:0]     head_q;
	logic [IW-1:0]     tail_q;

	// request and working registers
	logic                 op_q;
	logic [REQ_W-1:0]     req_q;
	logic [ADDR_BITS-1:0] faddr_q;
	logic [ADDR_BITS-1:0] off_q;
	logic [PW-1:0]        span_q;
	logic [PW-1:0]        prod_q;
	logic [IW-1:0]        idx_q;
	status_t              res_status_q;
	logic [ADDR_BITS-1:0] res_addr_q;
	logic [IW-1:0]        res_num_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// control strobes
	logic div_start;
	logic ring_we;
	logic map_we;
	logic map_wdata;

	// divider and store
	logic                 div_done;
	logic [ADDR_BITS-1:0] div_dividend;
	logic [ADDR_BITS-1:0] div_quotient;
	logic [SLOT_W-1:0]    div_remainder;
	logic [IW-1:0]        ring_rdata;
	logic                 map_rdata;

	// combinational helpers
	logic [ALIGN_W-1:0]   sh_clamp;
	logic [SLOT_W-1:0]    al_mask;
	logic [SLOT_W-1:0]    slot_bytes_new;
	logic [CW-1:0]        cnt_new;
	logic                 init_read;
	logic [IW-1:0]        idx_next;
	logic [IW-1:0]        tail_next;
	logic [IW-1:0]        head_next;
	logic [IW+SLOT_W-1:0] prod_full;
	logic [CW+SLOT_W-1:0] span_full;
	logic                 off_outside;
	logic                 slot_in_use;
	logic                 out_load;
	logic [CW+COUNT_W-1:0] in_use_ext;
	logic [CW+COUNT_W-1:0] total_ext;
	logic [IW+NUM_W-1:0]   num_ext;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// slot size on the first allocate: request rounded up to the alignment
	always_comb begin
		if (align_shift_q < ALIGN_MIN) begin
			sh_clamp = ALIGN_MIN;
		end else if (align_shift_q > ALIGN_MAX) begin
			sh_clamp = ALIGN_MAX;
		end else begin
			sh_clamp = align_shift_q;
		end
	end
	assign al_mask        = (SLOT_W'(1) << sh_clamp) - SLOT_W'(1);
	assign slot_bytes_new = ({1'b0, req_q} + al_mask) & ~al_mask;

	assign cnt_new = (div_quotient >= ADDR_BITS'(MAX_SLOTS)) ? CNT_MAX
		: div_quotient[CW-1:0];

	// the first slot_count pops hand out indices 0..count-1 in order
	assign init_read = init_taken_q < slot_count_q;
	assign idx_next  = init_read ? init_taken_q[IW-1:0] : ring_rdata;
	assign head_next = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;

	assign prod_full = idx_q * slot_bytes_q;
	assign span_full = slot_count_q * slot_bytes_q;

	assign off_outside = off_q >= ADDR_BITS'(span_q);
	// map entries past the handed-out initial indices were never allocated
	assign slot_in_use = (CW'(idx_q) < init_taken_q) && map_rdata;

	assign div_dividend = (state_q == S_SETUP_START) ? POOL_DIVIDEND : off_q;

	assign out_load = !out_valid_q || m_axis_tready;

	assign in_use_ext = {{COUNT_W{1'b0}}, slot_count_q - free_count_q};
	assign total_ext  = {{COUNT_W{1'b0}}, slot_count_q};
	assign num_ext    = {{NUM_W{1'b0}}, res_num_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		div_start = 1'b0;
		ring_we   = 1'b0;
		map_we    = 1'b0;
		map_wdata = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (op_q == OP_ALLOC) begin
					if (req_q == '0) begin
						state_nxt = S_DONE;
					end else if (slot_bytes_q == '0) begin
						state_nxt = S_SETUP_START;
					end else begin
						state_nxt = S_ALLOC_CHK;
					end
				end else begin
					if (slot_count_q == '0 || slot_bytes_q == '0) begin
						state_nxt = S_DONE;
					end else begin
						state_nxt = S_FREE_SPAN;
					end
				end
			end
			S_SETUP_START: begin
				div_start = 1'b1;
				state_nxt = S_SETUP_WAIT;
			end
			S_SETUP_WAIT: begin
				if (div_done) begin
					state_nxt = S_ALLOC_CHK;
				end
			end
			S_ALLOC_CHK: begin
				state_nxt = (free_count_q == '0) ? S_DONE : S_ALLOC_IDX;
			end
			S_ALLOC_IDX: begin
				state_nxt = S_ALLOC_MUL;
			end
			S_ALLOC_MUL: begin
				map_we    = 1'b1;
				map_wdata = 1'b1;
				state_nxt = S_ALLOC_ADD;
			end
			S_ALLOC_ADD: begin
				state_nxt = S_DONE;
			end
			S_FREE_SPAN: begin
				state_nxt = S_FREE_CMP;
			end
			S_FREE_CMP: begin
				if (off_outside) begin
					state_nxt = S_DONE;
				end else begin
					div_start = 1'b1;
					state_nxt = S_FREE_WAIT;
				end
			end
			S_FREE_WAIT: begin
				if (div_done) begin
					state_nxt = (div_remainder != '0) ? S_DONE : S_FREE_RD;
				end
			end
			S_FREE_RD: begin
				state_nxt = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				if (slot_in_use) begin
					map_we  = 1'b1;
					ring_we = 1'b1;
				end
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_shift_q <= ALIGN_RESET;
			pool_base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALIGN_SHIFT: align_shift_q <= cfg_data[ALIGN_W-1:0];
				CFG_POOL_BASE:   pool_base_q   <= cfg_data[ADDR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pool bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= '0;
			slot_count_q <= '0;
			free_count_q <= '0;
			init_taken_q <= '0;
			head_q       <= '0;
			tail_q       <= '0;
		end else begin
			case (state_q)
				S_DECODE: begin
					if (op_q == OP_ALLOC && req_q != '0 && slot_bytes_q == '0) begin
						slot_bytes_q <= slot_bytes_new;
					end
				end
				S_SETUP_WAIT: begin
					if (div_done) begin
						slot_count_q <= cnt_new;
						free_count_q <= cnt_new;
						head_q       <= '0;
						tail_q       <= (cnt_new >= CNT_MAX) ? '0 : cnt_new[IW-1:0];
					end
				end
				S_ALLOC_IDX: begin
					head_q       <= head_next;
					free_count_q <= free_count_q - 1'b1;
					if (init_read) begin
						init_taken_q <= init_taken_q + 1'b1;
					end
				end
				S_FREE_CHK: begin
					if (slot_in_use) begin
						tail_q       <= tail_next;
						free_count_q <= free_count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// request capture and datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= s_axis_tuser[0];
				req_q   <= s_axis_tdata[REQ_W-1:0];
				faddr_q <= s_axis_tdata[REQ_W+ADDR_BITS-1:REQ_W];
			end
			S_DECODE: begin
				off_q      <= faddr_q - pool_base_q;
				res_addr_q <= '0;
				res_num_q  <= '0;
				res_status_q <= ST_OK;
				if (op_q == OP_ALLOC) begin
					if (req_q == '0) begin
						res_status_q <= ST_ZERO;
					end
				end else if (slot_count_q == '0 || slot_bytes_q == '0) begin
					res_status_q <= ST_NOINIT;
				end
			end
			S_ALLOC_CHK: begin
				if (free_count_q == '0) begin
					res_status_q <= ST_NOSPACE;
				end
			end
			S_ALLOC_IDX: begin
				idx_q <= idx_next;
			end
			S_ALLOC_MUL: begin
				prod_q <= prod_full[PW-1:0];
			end
			S_ALLOC_ADD: begin
				res_addr_q <= pool_base_q + ADDR_BITS'(prod_q);
				res_num_q  <= idx_q;
			end
			S_FREE_SPAN: begin
				span_q <= span_full[PW-1:0];
			end
			S_FREE_CMP: begin
				if (off_outside) begin
					res_status_q <= ST_FOREIGN;
				end
			end
			S_FREE_WAIT: begin
				if (div_done) begin
					if (div_remainder != '0) begin
						res_status_q <= ST_FOREIGN;
					end
					idx_q <= div_quotient[IW-1:0];
				end
			end
			S_FREE_CHK: begin
				res_num_q <= idx_q;
				if (!slot_in_use) begin
					res_status_q <= ST_DOUBLE;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_load) begin
			out_data_q <= {2'b00,
				(free_count_q == '0),
				total_ext[COUNT_W-1:0],
				in_use_ext[COUNT_W-1:0],
				num_ext[NUM_W-1:0],
				res_addr_q,
				res_status_q};
		end
	end

	fspa_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (slot_bytes_q),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	fspa_store #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_store (
		.clk        (clk),
		.ring_we    (ring_we),
		.ring_waddr (tail_q),
		.ring_wdata (idx_q),
		.ring_raddr (head_q),
		.ring_rdata (ring_rdata),
		.map_we     (map_we),
		.map_addr   (idx_q),
		.map_wdata  (map_wdata),
		.map_rdata  (map_rdata)
	);

endmodule

>>> rtl/core/fspa_divider.sv
// fspa_divider: restoring divider, one quotient bit per cycle.
// Shared by slot count setup and address to index mapping. Uses fspa_pkg.
module fspa_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fspa_pkg::ADDR_BITS-1:0] dividend,
	input  logic [fspa_pkg::SLOT_W-1:0]    divisor,
	output logic                          done,
	output logic [fspa_pkg::ADDR_BITS-1:0] quotient,
	output logic [fspa_pkg::SLOT_W-1:0]    remainder
);
	import fspa_pkg::*;

	localparam int unsigned CNT_W = $clog2(ADDR_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADDR_BITS - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ADDR_BITS-1:0] quo_q;
	logic [SLOT_W-1:0]    rem_q;

	logic [SLOT_W:0] trial;
	logic [SLOT_W:0] diff;
	logic            ge;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, quo_q[ADDR_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[ADDR_BITS-2:0], ge};
			rem_q <= ge ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> rtl/core/fspa_store.sv
// fspa_store: free index ring and slot in-use map, both as synchronous memories.
// No reset on contents; the core tracks which entries hold written data. Uses fspa_pkg.
module fspa_store #(
	parameter int unsigned MAX_SLOTS = fspa_pkg::DEF_MAX_SLOTS
) (
	input  logic                         clk,
	input  logic                         ring_we,
	input  logic [$clog2(MAX_SLOTS)-1:0] ring_waddr,
	input  logic [$clog2(MAX_SLOTS)-1:0] ring_wdata,
	input  logic [$clog2(MAX_SLOTS)-1:0] ring_raddr,
	output logic [$clog2(MAX_SLOTS)-1:0] ring_rdata,
	input  logic                         map_we,
	input  logic [$clog2(MAX_SLOTS)-1:0] map_addr,
	input  logic                         map_wdata,
	output logic                         map_rdata
);
	import fspa_pkg::*;

	localparam int unsigned IW = $clog2(MAX_SLOTS);

	logic [IW-1:0] ring_mem [MAX_SLOTS];
	logic          map_mem  [MAX_SLOTS];
	logic [IW-1:0] ring_rd_q;
	logic          map_rd_q;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		ring_rd_q <= ring_mem[ring_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_addr] <= map_wdata;
		end else begin
			map_rd_q <= map_mem[map_addr];
		end
	end

	assign ring_rdata = ring_rd_q;
	assign map_rdata  = map_rd_q;

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for fixed_slot_pool_allocator_core.
// Keeps its own mirror of the pool, predicts every reply word and checks it field by field.
// Depends on fspa_pkg and the core RTL only.
module testbench;
	import fspa_pkg::*;

	localparam int unsigned POOL_CAPACITY = DEF_POOL_BYTES;
	localparam int unsigned SLOT_LIMIT    = DEF_MAX_SLOTS;

	typedef struct packed {
		status_t     status;
		logic [31:0] slot_addr;
		logic [7:0]  slot_number;
		logic [8:0]  slots_in_use;
		logic [8:0]  slot_total;
		logic        pool_full;
	} pool_reply_t;

	typedef enum int {
		FA_HELD,
		FA_SPARE,
		FA_MISALIGNED,
		FA_PAST_END,
		FA_ANY
	} free_kind_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = CFG_ALIGN_SHIFT;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// mirror of the pool state and registers
	logic [3:0]  align_reg;
	logic [31:0] base_reg;
	logic [16:0] unit_bytes;
	logic [8:0]  unit_count;
	logic [8:0]  spare_count;
	logic [7:0]  ring [SLOT_LIMIT];
	int unsigned ring_rd;
	int unsigned ring_wr;
	logic        held [SLOT_LIMIT];

	pool_reply_t answers_due[$];
	int unsigned mismatches = 0;
	logic        steady     = 1'b0;

	fixed_slot_pool_allocator_core i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic pool_reply_t pool_answer(input logic op, input logic [15:0] req,
			input logic [31:0] faddr);
		pool_reply_t r;
		int unsigned sh, al, cnt, idx, span;
		logic [31:0] off;
		r = '0;
		if (op == OP_ALLOC) begin
			if (req == 16'd0) begin
				r.status = ST_ZERO;
			end else begin
				if (unit_bytes == '0) begin
					// first real allocate fixes the slot size for good
					sh = (align_reg < ALIGN_MIN) ? ALIGN_MIN :
						(align_reg > ALIGN_MAX) ? ALIGN_MAX : align_reg;
					al = 1 << sh;
					unit_bytes = 17'((req + al - 1) & ~(al - 1));
					cnt = POOL_CAPACITY / unit_bytes;
					if (cnt > SLOT_LIMIT)
						cnt = SLOT_LIMIT;
					unit_count = 9'(cnt);
					spare_count = 9'(cnt);
					ring_rd = 0;
					ring_wr = (cnt >= SLOT_LIMIT) ? 0 : cnt;
				end
				if (spare_count == '0) begin
					r.status = ST_NOSPACE;
				end else begin
					idx = ring[ring_rd];
					ring_rd = (ring_rd + 1 >= SLOT_LIMIT) ? 0 : ring_rd + 1;
					spare_count--;
					held[idx] = 1'b1;
					r.slot_number = 8'(idx);
					r.slot_addr = base_reg + idx * unit_bytes;
				end
			end
		end else begin
			if (unit_count == '0 || unit_bytes == '0) begin
				r.status = ST_NOINIT;
			end else begin
				off = faddr - base_reg;
				span = unit_count * unit_bytes;
				if (off >= span || (off % unit_bytes) != 0) begin
					r.status = ST_FOREIGN;
				end else begin
					idx = off / unit_bytes;
					r.slot_number = 8'(idx);
					if (!held[idx]) begin
						r.status = ST_DOUBLE;
					end else begin
						held[idx] = 1'b0;
						ring[ring_wr] = 8'(idx);
						ring_wr = (ring_wr + 1 >= SLOT_LIMIT) ? 0 : ring_wr + 1;
						spare_count++;
					end
				end
			end
		end
		r.slots_in_use = unit_count - spare_count;
		r.slot_total = unit_count;
		r.pool_full = (spare_count == '0);
		return r;
	endfunction

	// address to hand back on a free, by kind; only used once the slot size is fixed
	function automatic logic [31:0] free_target(input free_kind_t kind);
		int unsigned list[$];
		logic [31:0] a;
		case (kind)
			FA_HELD, FA_SPARE: begin
				for (int i = 0; i < unit_count; i++)
					if (held[i] == (kind == FA_HELD))
						list.insert(list.size(), i);
				if (list.size() == 0)
					a = base_reg + $urandom_range(unit_count - 1) * unit_bytes;
				else
					a = base_reg + list[$urandom_range(list.size() - 1)] * unit_bytes;
			end
			FA_MISALIGNED: a = base_reg + $urandom_range(unit_count - 1) * unit_bytes
				+ $urandom_range(unit_bytes - 1, 1);
			FA_PAST_END: a = base_reg + (unit_count + $urandom_range(3)) * unit_bytes;
			default: a = $urandom;
		endcase
		return a;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : reply_check
		pool_reply_t want;
		m_axis_tready <= steady || ($urandom_range(99) >= 35);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answers_due.size() == 0) begin
				$error("reply word %h with no request outstanding", m_axis_tdata);
				mismatches++;
			end else begin
				want = answers_due[0];
				answers_due.delete(0);
				check_field("status", want.status, m_axis_tdata[2:0]);
				check_field("slot_addr", want.slot_addr, m_axis_tdata[34:3]);
				check_field("slot_number", want.slot_number, m_axis_tdata[42:35]);
				check_field("slots_in_use", want.slots_in_use, m_axis_tdata[51:43]);
				check_field("slot_total", want.slot_total, m_axis_tdata[60:52]);
				check_field("pool_full", want.pool_full, m_axis_tdata[61]);
				check_field("padding", '0, m_axis_tdata[63:62]);
			end
		end
	end

	// valid stays high between back-to-back words; only an idle cycle or settle lowers it
	task automatic issue_request(input logic op, input logic [15:0] req,
			input logic [31:0] faddr);
		while (!steady && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {faddr, req};
		do @(posedge clk); while (!s_axis_tready);
		answers_due.insert(answers_due.size(), pool_answer(op, req, faddr));
	endtask

	// stop sending and wait for every outstanding reply
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (answers_due.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ALIGN_SHIFT)
			align_reg = value[3:0];
		else
			base_reg = value;
		@(posedge clk);
	endtask

	task automatic traffic(input int unsigned n, input int unsigned alloc_pct,
			input int unsigned good_free_pct);
		free_kind_t k;
		repeat (n) begin
			if ($urandom_range(99) < alloc_pct) begin
				issue_request(OP_ALLOC, ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom),
					$urandom);
			end else begin
				if ($urandom_range(99) < good_free_pct)
					k = FA_HELD;
				else
					k = free_kind_t'($urandom_range(FA_ANY, FA_SPARE));
				issue_request(OP_FREE, 16'($urandom), free_target(k));
			end
		end
	endtask

	task automatic test_before_setup();
		issue_request(OP_FREE, 16'hFFFF, '0);
		issue_request(OP_FREE, 16'h0000, 32'hFFFF_FFFF);
		issue_request(OP_ALLOC, 16'd0, 32'hFFFF_FFFF);
		settle();
		// shifts 0 and 1 clamp to the minimum alignment
		write_reg(CFG_ALIGN_SHIFT, $urandom_range(5));
		write_reg(CFG_POOL_BASE, $urandom);
		issue_request(OP_ALLOC, 16'($urandom_range(100, 1)), $urandom);
		issue_request(OP_ALLOC, 16'd0, '0);
		issue_request(OP_ALLOC, 16'hFFFF, '0);
	endtask

	task automatic test_error_answers();
		logic [31:0] a;
		a = free_target(FA_HELD);
		issue_request(OP_FREE, 16'hFFFF, a);
		issue_request(OP_FREE, 16'h0000, a);
		issue_request(OP_FREE, '0, free_target(FA_MISALIGNED));
		issue_request(OP_FREE, '0, free_target(FA_PAST_END));
		issue_request(OP_FREE, '0, base_reg - unit_bytes);
		issue_request(OP_FREE, '0, 32'hFFFF_FFFF);
		issue_request(OP_FREE, '0, '0);
		issue_request(OP_ALLOC, 16'h8000, '0);
		issue_request(OP_ALLOC, 16'h0001, 32'hFFFF_FFFF);
	endtask

	task automatic test_fill_and_drain();
		// overshoot so the pool runs full, then empty, with zero-size words mixed in
		traffic(unit_count + unit_count / 8 + 4, 100, 100);
		traffic(unit_count + unit_count / 8 + 4, 0, 100);
	endtask

	task automatic test_register_sweep();
		logic [31:0] base;
		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: base = 32'hFFFF_FFFF;
				1: base = '0;
				2: base = 32'hFFFF_FC00;
				default: base = $urandom;
			endcase
			write_reg(CFG_ALIGN_SHIFT, (p == 0) ? 32'(ALIGN_MAX) : (p == 1) ? 32'hF :
				(p == 2) ? 32'h0 : $urandom_range(15));
			write_reg(CFG_POOL_BASE, base);
			traffic(120, 35 + 5 * p, 80);
		end
	endtask

	task automatic test_steady_stream();
		settle();
		steady <= 1'b1;
		traffic(200, 50, 85);
		settle();
		steady <= 1'b0;
	endtask

	task automatic test_random_mix();
		for (int p = 0; p < 6; p++) begin
			case (p % 3)
				0: traffic(120, 80, $urandom_range(95, 50));
				1: traffic(120, 20, $urandom_range(95, 50));
				default: traffic(120, $urandom_range(90, 10), 20);
			endcase
			if (p % 2 == 1)
				settle();
		end
	endtask

	initial begin
		for (int k = 0; k < SLOT_LIMIT; k++) begin
			ring[k] = 8'(k);
			held[k] = 1'b0;
		end
		align_reg = ALIGN_RESET;
		base_reg = '0;
		unit_bytes = '0;
		unit_count = '0;
		spare_count = '0;
		ring_rd = 0;
		ring_wr = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_setup();
		test_error_answers();
		test_fill_and_drain();
		test_register_sweep();
		test_steady_stream();
		test_random_mix();
		settle();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
